/* rtl/file_lock_table_assert.svh */
// assertion macros for the file lock table
// expect clk_i and rst_ni in the scope of the module that uses them
`ifndef FILE_LOCK_TABLE_ASSERT_SVH
`define FILE_LOCK_TABLE_ASSERT_SVH

// checked outside reset
`define FLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/flt_pkg.sv */
// shared types and codes for the file lock table
// no dependencies
package flt_pkg;

  localparam int FILE_W  = 16;
  localparam int OWNER_W = 10;
  localparam int LIMIT_W = 7;

  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_SHARED = 2'd1;
  localparam logic [1:0] MODE_EXCL   = 2'd2;
  localparam logic [1:0] MODE_UNLOCK = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_WOULDBL = 2'd1;
  localparam logic [1:0] ST_RETRY   = 2'd2;
  localparam logic [1:0] ST_NOENTRY = 2'd3;

  localparam logic [1:0] HELD_NONE   = 2'd0;
  localparam logic [1:0] HELD_SHARED = 2'd1;
  localparam logic [1:0] HELD_EXCL   = 2'd2;

  // request held steady while its token walks the cell row
  typedef struct packed {
    logic [1:0]         mode;
    logic [FILE_W-1:0]  file_id;
    logic [OWNER_W-1:0] owner_id;
  } req_t;

  // scan summary handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               found;
    logic               holder_excl;
    logic [OWNER_W-1:0] holder_owner;
    logic               conflict;
    logic               have_own;
    logic               have_free;
  } token_t;

  // update broadcast to the marked cell after the scan
  typedef struct packed {
    logic               wr_own;
    logic               wr_free;
    logic               unlock;
    logic [FILE_W-1:0]  file_id;
    logic [OWNER_W-1:0] owner_id;
    logic               excl;
  } cmd_t;

endpackage

/* rtl/flt_if.sv */
// request and response channel interfaces for the file lock table
// depends on flt_pkg
interface flt_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic                        nonblocking;
  logic [flt_pkg::FILE_W-1:0]  file_id;
  logic [flt_pkg::OWNER_W-1:0] owner_id;

  modport source (output valid, mode, nonblocking, file_id, owner_id, input ready);
  modport sink (input valid, mode, nonblocking, file_id, owner_id, output ready);
endinterface

interface flt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [1:0]                  held_type;
  logic [flt_pkg::OWNER_W-1:0] holder_id;

  modport source (output valid, status, held_type, holder_id, input ready);
  modport sink (input valid, status, held_type, holder_id, output ready);
endinterface

/* rtl/file_lock_table.sv */
// channel     | dir | payload
// req_i       | in  | mode, nonblocking, file_id, owner_id
// rsp_o       | out | status, held_type, holder_id
// cfg_*       | in  | entry_limit write, no read-back
//
// in each transaction a token walks the row of entry cells one cell per cycle,
// then the decision is registered and, once rsp_o is free, loaded into the output
// one transaction in flight; the next is taken while a response waits in rsp_o
// a stalled response holds the decision and blocks the next scan result only
// reset clears every entry valid bit and the use count at once
// top level of the file lock table, a row of flt_cell entries
// depends on flt_pkg, flt_if, flt_cell and file_lock_table_assert.svh
`include "file_lock_table_assert.svh"

module file_lock_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  flt_req_if.sink                     req_i,
  flt_rsp_if.source                   rsp_o,
  input  logic                        cfg_we_i,
  input  logic [flt_pkg::LIMIT_W-1:0] cfg_wdata_i
);

  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int CmpW = (CntW > flt_pkg::LIMIT_W) ? CntW : flt_pkg::LIMIT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                  state_q, state_d;
  flt_pkg::req_t               req_q;
  logic                        nb_q;
  logic                        inj_q;
  logic [flt_pkg::LIMIT_W-1:0] limit_q;
  logic [CntW-1:0]             used_q, used_d;
  flt_pkg::cmd_t               cmd_q, cmd_d;

  logic [1:0]                  res_status_q, res_status_d;
  logic [1:0]                  res_held_q, res_held_d;
  logic [flt_pkg::OWNER_W-1:0] res_holder_q, res_holder_d;

  logic                        out_valid_q;
  logic [1:0]                  out_status_q;
  logic [1:0]                  out_held_q;
  logic [flt_pkg::OWNER_W-1:0] out_holder_q;

  flt_pkg::token_t tok [TABLE_ENTRIES+1];
  flt_pkg::token_t tail;

  logic            accept, out_free, full;
  logic [CmpW-1:0] lim, used_ext;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    tok[0]     = '0;
    tok[0].vld = inj_q;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    flt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req_q),
      .cmd_i  (cmd_q),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  assign tail     = tok[TABLE_ENTRIES];
  assign used_ext = CmpW'(used_q);
  assign lim      = (CmpW'(limit_q) > CmpW'(TABLE_ENTRIES)) ? CmpW'(TABLE_ENTRIES)
                                                            : CmpW'(limit_q);
  assign full     = (used_ext >= lim);

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    cmd_d        = '0;
    cmd_d.file_id  = req_q.file_id;
    cmd_d.owner_id = req_q.owner_id;
    cmd_d.excl     = (req_q.mode == flt_pkg::MODE_EXCL);
    res_status_d = res_status_q;
    res_held_d   = res_held_q;
    res_holder_d = res_holder_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.vld) begin
          state_d      = S_HOLD;
          res_status_d = flt_pkg::ST_DONE;
          res_held_d   = flt_pkg::HELD_NONE;
          res_holder_d = '0;
          case (req_q.mode)
            flt_pkg::MODE_QUERY: begin
              if (tail.found) begin
                res_held_d   = tail.holder_excl ? flt_pkg::HELD_EXCL : flt_pkg::HELD_SHARED;
                res_holder_d = tail.holder_owner;
              end
            end
            flt_pkg::MODE_UNLOCK: begin
              if (tail.have_own) begin
                cmd_d.unlock = 1'b1;
                if (used_q != '0) begin
                  used_d = used_q - 1'b1;
                end
              end
            end
            default: begin
              if (tail.conflict) begin
                res_status_d = nb_q ? flt_pkg::ST_WOULDBL : flt_pkg::ST_RETRY;
              end else if (tail.have_own) begin
                cmd_d.wr_own = 1'b1;
              end else if (full || !tail.have_free) begin
                res_status_d = flt_pkg::ST_NOENTRY;
              end else begin
                cmd_d.wr_free = 1'b1;
                used_d        = used_q + 1'b1;
              end
            end
          endcase
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inj_q       <= 1'b0;
      used_q      <= '0;
      limit_q     <= flt_pkg::LIMIT_W'(64);
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= accept;
      used_q  <= used_d;
      cmd_q   <= cmd_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (state_q == S_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.mode     <= req_i.mode;
      req_q.file_id  <= req_i.file_id;
      req_q.owner_id <= req_i.owner_id;
      nb_q           <= req_i.nonblocking;
    end
    res_status_q <= res_status_d;
    res_held_q   <= res_held_d;
    res_holder_q <= res_holder_d;
    if (state_q == S_HOLD && out_free) begin
      out_status_q <= res_status_q;
      out_held_q   <= res_held_q;
      out_holder_q <= res_holder_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.held_type = out_held_q;
  assign rsp_o.holder_id = out_holder_q;

  `FLT_ASSERT_ALWAYS(a_used_bound, (used_q <= CntW'(TABLE_ENTRIES)), "use count above table size")
  `FLT_ASSERT(a_cmd_after_scan, ((cmd_q.wr_own || cmd_q.wr_free || cmd_q.unlock) |-> $past(state_q == S_SCAN)), "table update outside scan end")
  `FLT_ASSERT(a_one_cmd, ($countones({cmd_q.wr_own, cmd_q.wr_free, cmd_q.unlock}) <= 1), "more than one table update kind")
  `FLT_ASSERT(a_tail_in_scan, (tail.vld |-> (state_q == S_SCAN)), "token left the row outside a scan")
  `FLT_ASSERT(a_single_inject, (inj_q |=> !inj_q), "token injected twice")

endmodule

/* rtl/flt_cell.sv */
// one lock table entry with its stage of the scan token chain
// depends on flt_pkg
module flt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  flt_pkg::req_t   req_i,
  input  flt_pkg::cmd_t   cmd_i,
  input  flt_pkg::token_t tok_i,
  output flt_pkg::token_t tok_o
);

  logic                        valid_q;
  logic [flt_pkg::FILE_W-1:0]  file_q;
  logic [flt_pkg::OWNER_W-1:0] owner_q;
  logic                        excl_q;
  logic                        own_mark_q;
  logic                        free_mark_q;
  flt_pkg::token_t             tok_q, tok_d;

  logic hit_file, hit_own, want_excl, do_write;

  assign hit_file  = valid_q && (file_q == req_i.file_id);
  assign hit_own   = hit_file && (owner_q == req_i.owner_id);
  assign want_excl = (req_i.mode == flt_pkg::MODE_EXCL);
  assign do_write  = (cmd_i.wr_own && own_mark_q) || (cmd_i.wr_free && free_mark_q);

  always_comb begin
    tok_d = tok_i;
    if (hit_file && !tok_i.found) begin
      tok_d.found        = 1'b1;
      tok_d.holder_excl  = excl_q;
      tok_d.holder_owner = owner_q;
    end
    if (hit_own) begin
      tok_d.have_own = 1'b1;
    end else if (hit_file && (want_excl || excl_q)) begin
      tok_d.conflict = 1'b1;
    end
    if (!valid_q) begin
      tok_d.have_free = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      own_mark_q  <= 1'b0;
      free_mark_q <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.vld) begin
        own_mark_q  <= hit_own && !tok_i.have_own;
        free_mark_q <= !valid_q && !tok_i.have_free;
      end
      if (cmd_i.unlock && own_mark_q) begin
        valid_q <= 1'b0;
      end else if (do_write) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      file_q  <= cmd_i.file_id;
      owner_q <= cmd_i.owner_id;
      excl_q  <= cmd_i.excl;
    end
  end

  assign tok_o = tok_q;

endmodule

/* tb/tb_file_lock_table.sv */
`timescale 1ns / 1ps
// self-checking testbench for the file lock table: directed and random lock traffic
// checked against an in-bench model of the table, with random stalls on both channels
// depends on flt_pkg, flt_if and file_lock_table
module tb_file_lock_table;

  localparam int TABLE_ENTRIES = 64;
  localparam int SCAN_CYCLES   = TABLE_ENTRIES + 3;

  typedef struct {
    logic [1:0]                  mode;
    logic                        nb;
    logic [flt_pkg::FILE_W-1:0]  file;
    logic [flt_pkg::OWNER_W-1:0] owner;
  } lock_req_t;

  typedef struct {
    logic [1:0]                  status;
    logic [1:0]                  held;
    logic [flt_pkg::OWNER_W-1:0] holder;
  } lock_answer_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [flt_pkg::LIMIT_W-1:0] cfg_wdata_i;

  flt_req_if req_if ();
  flt_rsp_if rsp_if ();

  file_lock_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // model of the lock table
  bit                          slot_valid [TABLE_ENTRIES];
  logic [flt_pkg::FILE_W-1:0]  slot_file  [TABLE_ENTRIES];
  logic [flt_pkg::OWNER_W-1:0] slot_owner [TABLE_ENTRIES];
  bit                          slot_excl  [TABLE_ENTRIES];
  int                          slots_used = 0;
  int                          limit_model = 64;

  lock_req_t    requests_todo[$];
  lock_answer_t answers_due[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatch_cnt = 0;

  logic [flt_pkg::FILE_W-1:0]  file_pool  [32];
  logic [flt_pkg::OWNER_W-1:0] owner_pool [16];

  function automatic lock_answer_t grant_or_refuse(lock_req_t r);
    lock_answer_t a;
    bit want_excl, conflict, have_own, have_free;
    int own_idx, free_idx, lim;
    a.status = flt_pkg::ST_DONE;
    a.held   = flt_pkg::HELD_NONE;
    a.holder = '0;
    want_excl = (r.mode == flt_pkg::MODE_EXCL);
    conflict = 0;
    have_own = 0;
    have_free = 0;
    own_idx = 0;
    free_idx = 0;
    if (r.mode == flt_pkg::MODE_QUERY) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (slot_valid[k] && slot_file[k] == r.file) begin
          a.held   = slot_excl[k] ? flt_pkg::HELD_EXCL : flt_pkg::HELD_SHARED;
          a.holder = slot_owner[k];
          return a;
        end
      end
      return a;
    end
    if (r.mode == flt_pkg::MODE_UNLOCK) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (slot_valid[k] && slot_file[k] == r.file && slot_owner[k] == r.owner) begin
          slot_valid[k] = 0;
          if (slots_used > 0) slots_used--;
          break;
        end
      end
      return a;
    end
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (!slot_valid[k]) begin
        if (!have_free) begin
          have_free = 1;
          free_idx = k;
        end
      end else if (slot_file[k] == r.file) begin
        if (slot_owner[k] == r.owner) begin
          if (!have_own) begin
            have_own = 1;
            own_idx = k;
          end
        end else if (want_excl || slot_excl[k]) begin
          conflict = 1;
        end
      end
    end
    if (conflict) begin
      a.status = r.nb ? flt_pkg::ST_WOULDBL : flt_pkg::ST_RETRY;
      return a;
    end
    if (!have_own) begin
      lim = (limit_model > TABLE_ENTRIES) ? TABLE_ENTRIES : limit_model;
      if (slots_used >= lim || !have_free) begin
        a.status = flt_pkg::ST_NOENTRY;
        return a;
      end
      own_idx = free_idx;
      slots_used++;
    end
    slot_valid[own_idx] = 1;
    slot_file[own_idx]  = r.file;
    slot_owner[own_idx] = r.owner;
    slot_excl[own_idx]  = want_excl;
    return a;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 50) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_req
    lock_req_t seen, nxt;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen.mode  = req_if.mode;
        seen.nb    = req_if.nonblocking;
        seen.file  = req_if.file_id;
        seen.owner = req_if.owner_id;
        answers_due.push_back(grant_or_refuse(seen));
      end
      if (!req_if.valid || req_if.ready) begin
        if (requests_todo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = requests_todo.pop_front();
          req_if.valid       <= 1'b1;
          req_if.mode        <= nxt.mode;
          req_if.nonblocking <= nxt.nb;
          req_if.file_id     <= nxt.file;
          req_if.owner_id    <= nxt.owner;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin : watch_rsp
    lock_answer_t exp;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction status %0d", rsp_if.status));
        end else begin
          exp = answers_due.pop_front();
          if (rsp_if.status !== exp.status || rsp_if.held_type !== exp.held ||
              rsp_if.holder_id !== exp.holder)
            report_mismatch($sformatf("status %0d/%0d held %0d/%0d holder %0d/%0d (got/exp)",
                                      rsp_if.status, exp.status, rsp_if.held_type, exp.held,
                                      rsp_if.holder_id, exp.holder));
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_req(logic [1:0] mode, logic nb, logic [flt_pkg::FILE_W-1:0] file,
                          logic [flt_pkg::OWNER_W-1:0] owner);
    lock_req_t r;
    r.mode = mode;
    r.nb = nb;
    r.file = file;
    r.owner = owner;
    requests_todo.push_back(r);
  endtask

  // polled away from the rising edge so driver updates have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (requests_todo.size() != 0 || req_if.valid || answers_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(int value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[flt_pkg::LIMIT_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_model = value & 7'h7f;
  endtask

  task automatic random_phase(int limit, int send_pct, int recv_pct, int count,
                              int nf, int no, int unlock_w);
    int r, shared_w;
    logic [1:0] mode;
    logic [flt_pkg::FILE_W-1:0] f;
    logic [flt_pkg::OWNER_W-1:0] o;
    write_limit(limit);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    foreach (file_pool[i]) file_pool[i] = flt_pkg::FILE_W'($urandom);
    foreach (owner_pool[i]) owner_pool[i] = flt_pkg::OWNER_W'($urandom);
    shared_w = (80 - unlock_w) / 2;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < unlock_w) mode = flt_pkg::MODE_UNLOCK;
      else if (r < unlock_w + 20) mode = flt_pkg::MODE_QUERY;
      else if (r < unlock_w + 20 + shared_w) mode = flt_pkg::MODE_SHARED;
      else mode = flt_pkg::MODE_EXCL;
      f = ($urandom_range(9) == 0) ? flt_pkg::FILE_W'($urandom)
                                   : file_pool[$urandom_range(nf - 1)];
      o = ($urandom_range(9) == 0) ? flt_pkg::OWNER_W'($urandom)
                                   : owner_pool[$urandom_range(no - 1)];
      push_req(mode, 1'($urandom_range(1)), f, o);
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.mode        = flt_pkg::MODE_QUERY;
    req_if.nonblocking = 1'b0;
    req_if.file_id     = '0;
    req_if.owner_id    = '0;
    rsp_if.ready       = 1'b0;
    foreach (slot_valid[k]) slot_valid[k] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // an empty-table query and unlock, then sharing, conflicts, upgrade and downgrade on one file
    push_req(flt_pkg::MODE_QUERY,  1'b0, 16'h0000, 10'd0);
    push_req(flt_pkg::MODE_UNLOCK, 1'b1, 16'hffff, 10'd1023);
    push_req(flt_pkg::MODE_SHARED, 1'b0, 16'hffff, 10'd0);
    push_req(flt_pkg::MODE_SHARED, 1'b1, 16'hffff, 10'd1023);
    push_req(flt_pkg::MODE_QUERY,  1'b0, 16'hffff, 10'd5);
    push_req(flt_pkg::MODE_EXCL,   1'b1, 16'hffff, 10'd5);
    push_req(flt_pkg::MODE_EXCL,   1'b0, 16'hffff, 10'd5);
    push_req(flt_pkg::MODE_EXCL,   1'b0, 16'hffff, 10'd0);
    push_req(flt_pkg::MODE_UNLOCK, 1'b0, 16'hffff, 10'd1023);
    push_req(flt_pkg::MODE_EXCL,   1'b0, 16'hffff, 10'd0);
    push_req(flt_pkg::MODE_SHARED, 1'b1, 16'hffff, 10'd7);
    push_req(flt_pkg::MODE_QUERY,  1'b0, 16'hffff, 10'd7);
    push_req(flt_pkg::MODE_SHARED, 1'b0, 16'hffff, 10'd0);
    push_req(flt_pkg::MODE_QUERY,  1'b1, 16'hffff, 10'd0);
    push_req(flt_pkg::MODE_UNLOCK, 1'b0, 16'hffff, 10'd0);
    push_req(flt_pkg::MODE_QUERY,  1'b0, 16'hffff, 10'd0);

    // limit of one, then reuse of the own entry with the table at its limit
    write_limit(1);
    push_req(flt_pkg::MODE_EXCL,   1'b0, 16'h1234, 10'h155);
    push_req(flt_pkg::MODE_SHARED, 1'b0, 16'h2222, 10'h2aa);
    push_req(flt_pkg::MODE_SHARED, 1'b1, 16'h1234, 10'h155);
    push_req(flt_pkg::MODE_UNLOCK, 1'b0, 16'h1234, 10'h155);

    // limit of zero
    write_limit(0);
    push_req(flt_pkg::MODE_SHARED, 1'b0, 16'h0000, 10'd0);
    push_req(flt_pkg::MODE_EXCL,   1'b1, 16'h5a5a, 10'h3ff);

    random_phase(64,  0,  0,  175, 8,  6, 25);
    random_phase(5,   47, 0,  175, 8,  6, 25);
    random_phase(127, 0,  47, 175, 32, 16, 5);
    random_phase(3,   38, 38, 175, 8,  6, 25);
    random_phase(1,   0,  0,  175, 4,  4, 25);
    random_phase(0,   47, 0,  175, 8,  6, 30);
    random_phase(40,  0,  47, 175, 32, 16, 5);
    random_phase(64,  38, 38, 175, 8,  6, 40);

    wait_idle();
    repeat (SCAN_CYCLES + 10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
